/* hw/rtl/cfrd_pkg.sv */
package cfrd_pkg;

  localparam logic [31:0] MAGIC_PLAIN   = 32'hA1B2C3D4;
  localparam logic [31:0] MAGIC_SWAPPED = 32'hD4C3B2A1;

  // last byte position of each header
  localparam logic [4:0] GLOBAL_LAST_POS = 5'd23;
  localparam logic [4:0] RECORD_LAST_POS = 5'd15;

  // record header word end positions
  localparam logic [4:0] POS_WORD0 = 5'd3;
  localparam logic [4:0] POS_WORD1 = 5'd7;
  localparam logic [4:0] POS_WORD2 = 5'd11;

  typedef enum logic [1:0] {
    PH_GLOBAL  = 2'd0,
    PH_RECORD  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_HALT    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_PAYLOAD   = 2'd1,
    KIND_BAD_MAGIC = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [31:0] ts_seconds;
    logic [31:0] ts_microseconds;
    logic [31:0] capture_length;
    logic [7:0]  payload_byte;
    logic        last_in_packet;
  } result_t;

  function automatic logic [31:0] byte_reverse(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

/* hw/rtl/cfrd_byte_if.sv */
interface cfrd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

/* hw/rtl/cfrd_result_if.sv */
interface cfrd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] ts_seconds;
  logic [31:0] ts_microseconds;
  logic [31:0] capture_length;
  logic [7:0]  payload_byte;
  logic        last_in_packet;

  modport source (output valid, output result_kind, output ts_seconds,
                  output ts_microseconds, output capture_length,
                  output payload_byte, output last_in_packet, input ready);
  modport sink   (input valid, input result_kind, input ts_seconds,
                  input ts_microseconds, input capture_length,
                  input payload_byte, input last_in_packet, output ready);
endinterface

/* hw/rtl/cfrd_parser.sv */
module cfrd_parser
  import cfrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_in,
  output logic       emit,
  output result_t    result
);

  phase_t      phase_r, phase_nxt;
  logic [4:0]  count_r, count_nxt;
  logic        swap_r, swap_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] sec_r, sec_nxt;
  logic [31:0] usec_r, usec_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [31:0] field;
  logic [31:0] remain_dec;
  logic        emit_c;
  result_t     res_c;

  assign word_nxt   = {byte_in, word_r[31:8]};
  assign field      = swap_r ? byte_reverse(word_nxt) : word_nxt;
  assign remain_dec = remain_r - 32'd1;

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    swap_nxt   = swap_r;
    sec_nxt    = sec_r;
    usec_nxt   = usec_r;
    remain_nxt = remain_r;
    emit_c     = 1'b0;
    res_c      = '0;
    case (phase_r)
      PH_PAYLOAD: begin
        remain_nxt           = remain_dec;
        emit_c               = 1'b1;
        res_c.result_kind    = KIND_PAYLOAD;
        res_c.payload_byte   = byte_in;
        res_c.last_in_packet = (remain_dec == '0);
        if (remain_dec == '0) begin
          phase_nxt = PH_RECORD;
          count_nxt = '0;
        end
      end
      PH_GLOBAL: begin
        count_nxt = count_r + 5'd1;
        if (count_r == POS_WORD0) begin
          if (word_nxt == MAGIC_PLAIN) begin
            swap_nxt = 1'b0;
          end else if (word_nxt == MAGIC_SWAPPED) begin
            swap_nxt = 1'b1;
          end else begin
            phase_nxt         = PH_HALT;
            emit_c            = 1'b1;
            res_c.result_kind = KIND_BAD_MAGIC;
          end
        end
        if (count_r >= GLOBAL_LAST_POS && phase_nxt != PH_HALT) begin
          phase_nxt = PH_RECORD;
          count_nxt = '0;
        end
      end
      PH_RECORD: begin
        count_nxt = count_r + 5'd1;
        if (count_r == POS_WORD0) begin
          sec_nxt = field;
        end else if (count_r == POS_WORD1) begin
          usec_nxt = field;
        end else if (count_r == POS_WORD2) begin
          remain_nxt = field;
        end
        if (count_r >= RECORD_LAST_POS) begin
          count_nxt             = '0;
          emit_c                = 1'b1;
          res_c.result_kind     = KIND_HEADER;
          res_c.ts_seconds      = sec_r;
          res_c.ts_microseconds = usec_r;
          res_c.capture_length  = remain_r;
          res_c.last_in_packet  = (remain_r == '0);
          phase_nxt             = (remain_r == '0) ? PH_RECORD : PH_PAYLOAD;
        end
      end
      default: begin
        // halted after a bad magic word: drop everything
      end
    endcase
  end

  assign emit   = step & emit_c;
  assign result = res_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_GLOBAL;
      count_r  <= '0;
      swap_r   <= 1'b0;
      word_r   <= '0;
      sec_r    <= '0;
      usec_r   <= '0;
      remain_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      swap_r   <= swap_nxt;
      sec_r    <= sec_nxt;
      usec_r   <= usec_nxt;
      remain_r <= remain_nxt;
      if (phase_r == PH_GLOBAL || phase_r == PH_RECORD) begin
        word_r <= word_nxt;
      end
    end
  end

endmodule

/* hw/rtl/capture_file_record_deframer_top.sv */
// Channel   Dir  Payload                                         Handshake
// in_ch     in   in_byte                                         valid/ready
// out_ch    out  result_kind, ts_seconds, ts_microseconds,       valid/ready
//                capture_length, payload_byte, last_in_packet
//
// One byte per cycle sustained while out_ch is ready; a byte transferred in passes
// through the input register, then the result register, before its result can
// transfer out.
// rst_n is synchronous, active low; after reset the global header is expected.
// A stalled result register holds the input register, which then holds in_ch.
module capture_file_record_deframer_top
  import cfrd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  cfrd_byte_if.sink     in_ch,
  cfrd_result_if.source out_ch
);

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       out_v_r;
  result_t    res_r;
  logic       advance;
  logic       emit;
  result_t    result;

  // advance the held byte when the result register is free or draining
  assign advance     = in_v_r & (~out_v_r | out_ch.ready);
  assign in_ch.ready = ~in_v_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.in_byte;
    end
  end

  cfrd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .byte_in (in_byte_r),
    .emit    (emit),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (emit) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= result;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.result_kind     = res_r.result_kind;
  assign out_ch.ts_seconds      = res_r.ts_seconds;
  assign out_ch.ts_microseconds = res_r.ts_microseconds;
  assign out_ch.capture_length  = res_r.capture_length;
  assign out_ch.payload_byte    = res_r.payload_byte;
  assign out_ch.last_in_packet  = res_r.last_in_packet;

`ifndef SYNTHESIS
  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(emit && out_v_r && !out_ch.ready))
    else $error("result overwritten while stalled");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r && $stable(in_byte_r))
    else $error("held byte lost during stall");

  a_header_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.result_kind == KIND_HEADER
      |-> res_r.last_in_packet == (res_r.capture_length == 32'd0))
    else $error("header last flag disagrees with length");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.result_kind == KIND_PAYLOAD
      |-> res_r.ts_seconds == 32'd0 && res_r.capture_length == 32'd0)
    else $error("payload result carries header fields");
`endif

endmodule

/* dv/capture_record_checker.sv */
module capture_record_checker
  import cfrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [31:0] out_seconds,
  input  logic [31:0] out_microseconds,
  input  logic [31:0] out_length,
  input  logic [7:0]  out_payload,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_results,
  output int          headers_seen,
  output int          payload_seen,
  output int          bad_magic_seen
);

  phase_t      phase;
  logic [4:0]  hdr_pos;
  logic        big_endian;
  logic [31:0] word_acc;
  logic [31:0] seconds_q;
  logic [31:0] micros_q;
  logic [31:0] bytes_left;
  result_t     expected_q[$];
  int          mismatches = 0;
  int          n_headers = 0;
  int          n_payload = 0;
  int          n_bad = 0;

  // Fields are stored in file order; present them in host order.
  function automatic logic [31:0] host_word(input logic [31:0] w, input logic swap);
    logic [31:0] r;
    r = w;
    if (swap) begin
      for (int i = 0; i < 4; i++) r[8*i +: 8] = w[8*(3-i) +: 8];
    end
    return r;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    result_t    r;
    logic [4:0] pos;
    r = '0;
    case (phase)
      PH_HALT: ;
      PH_PAYLOAD: begin
        bytes_left = bytes_left - 32'd1;
        r.result_kind    = KIND_PAYLOAD;
        r.payload_byte   = b;
        r.last_in_packet = (bytes_left == 32'd0);
        expected_q.push_back(r);
        if (bytes_left == 32'd0) begin
          phase   = PH_RECORD;
          hdr_pos = '0;
        end
      end
      default: begin
        pos      = hdr_pos;
        word_acc = {b, word_acc[31:8]};
        hdr_pos  = hdr_pos + 5'd1;
        if (phase == PH_GLOBAL) begin
          if (pos == POS_WORD0) begin
            if (word_acc == MAGIC_PLAIN) begin
              big_endian = 1'b0;
            end else if (word_acc == MAGIC_SWAPPED) begin
              big_endian = 1'b1;
            end else begin
              // halt for good; nothing more comes out until reset
              phase         = PH_HALT;
              r.result_kind = KIND_BAD_MAGIC;
              expected_q.push_back(r);
            end
          end
          if (phase == PH_GLOBAL && pos == GLOBAL_LAST_POS) begin
            phase   = PH_RECORD;
            hdr_pos = '0;
          end
        end else begin
          if (pos == POS_WORD0) seconds_q = host_word(word_acc, big_endian);
          else if (pos == POS_WORD1) micros_q = host_word(word_acc, big_endian);
          else if (pos == POS_WORD2) bytes_left = host_word(word_acc, big_endian);
          if (pos == RECORD_LAST_POS) begin
            hdr_pos            = '0;
            r.result_kind      = KIND_HEADER;
            r.ts_seconds       = seconds_q;
            r.ts_microseconds  = micros_q;
            r.capture_length   = bytes_left;
            r.last_in_packet   = (bytes_left == 32'd0);
            expected_q.push_back(r);
            phase = (bytes_left == 32'd0) ? PH_RECORD : PH_PAYLOAD;
          end
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      phase      = PH_GLOBAL;
      hdr_pos    = '0;
      big_endian = 1'b0;
      word_acc   = '0;
      seconds_q  = '0;
      micros_q   = '0;
      bytes_left = '0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (out_kind == KIND_HEADER) n_headers++;
        else if (out_kind == KIND_PAYLOAD) n_payload++;
        else n_bad++;
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer: kind 0x%0h", out_kind);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          compare_field("result_kind", 32'(want.result_kind), 32'(out_kind));
          compare_field("ts_seconds", want.ts_seconds, out_seconds);
          compare_field("ts_microseconds", want.ts_microseconds, out_microseconds);
          compare_field("capture_length", want.capture_length, out_length);
          compare_field("payload_byte", 32'(want.payload_byte), 32'(out_payload));
          compare_field("last_in_packet", 32'(want.last_in_packet), 32'(out_last));
        end
      end
      if (in_valid && in_ready) deframe_byte(in_byte);
    end
    fail_count      <= mismatches;
    pending_results <= expected_q.size();
    headers_seen    <= n_headers;
    payload_seen    <= n_payload;
    bad_magic_seen  <= n_bad;
  end

endmodule

/* dv/tb_top.sv */
module tb_top;
  import cfrd_pkg::*;

  localparam int          RANDOM_BYTES    = 560;
  localparam int          HOLD_LEN        = 120;
  localparam int          DRAIN_CYCLES    = 8;
  localparam logic [31:0] MICROS_PER_SEC  = 32'd1_000_000;
  localparam logic [31:0] NSEC_MAGIC      = 32'hA1B23C4D;
  localparam logic [31:0] NSEC_MAGIC_SWAP = 32'h4D3CB2A1;

  logic clk = 1'b0;
  logic rst_n;

  cfrd_byte_if   in_ch();
  cfrd_result_if out_ch();

  capture_file_record_deframer_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int fail_count;
  int pending_results;
  int headers_seen;
  int payload_seen;
  int bad_magic_seen;

  capture_record_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_byte          (in_ch.in_byte),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_kind         (out_ch.result_kind),
    .out_seconds      (out_ch.ts_seconds),
    .out_microseconds (out_ch.ts_microseconds),
    .out_length       (out_ch.capture_length),
    .out_payload      (out_ch.payload_byte),
    .out_last         (out_ch.last_in_packet),
    .fail_count       (fail_count),
    .pending_results  (pending_results),
    .headers_seen     (headers_seen),
    .payload_seen     (payload_seen),
    .bad_magic_seen   (bad_magic_seen)
  );

  always #2 clk = ~clk;

  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_req = 0;
  int   hold_ack = 0;
  int   hold_cycles = 0;
  int   bytes_sent = 0;
  logic file_big_endian = 1'b0;

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_cycles  <= HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) begin
      send_byte(file_big_endian ? w[8*(3-i) +: 8] : w[8*i +: 8]);
    end
  endtask

  task automatic send_record_header(input logic [31:0] secs, input logic [31:0] usecs,
                                    input logic [31:0] len);
    send_word(secs);
    send_word(usecs);
    send_word(len);
    send_word($urandom);
  endtask

  task automatic send_payload(input int n);
    repeat (n) send_byte(8'($urandom_range(255)));
  endtask

  // Traffic shape follows progress through the random part.
  task automatic set_traffic(input int done);
    case (done * 4 / RANDOM_BYTES)
      0: begin idle_pct = 0;  stall_pct <= 0;  end
      1: begin idle_pct = 86; stall_pct <= 0;  end
      2: begin idle_pct = 0;  stall_pct <= 86; end
      default: begin idle_pct = 36; stall_pct <= 36; end
    endcase
  endtask

  initial begin
    int          random_start;
    int          roll;
    int          len;
    logic [31:0] bad_word;
    logic [31:0] usecs;
    logic        bad_run;

    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    rst_n         <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // The magic word is checked once per reset, so a run either parses or halts.
    bad_run = ($urandom_range(7) == 0);
    file_big_endian = bad_run ? 1'b0 : 1'($urandom_range(1));

    if (bad_run) begin
      roll = $urandom_range(2);
      if (roll == 0) bad_word = NSEC_MAGIC;
      else if (roll == 1) bad_word = NSEC_MAGIC_SWAP;
      else bad_word = MAGIC_PLAIN ^ (32'd1 << $urandom_range(31));
      send_word(bad_word);
      random_start = bytes_sent;
      hold_req <= hold_req + 1;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
        set_traffic(bytes_sent - random_start);
        send_byte(8'($urandom_range(255)));
      end
    end else begin
      send_word(MAGIC_PLAIN);
      repeat (5) send_word($urandom);

      send_record_header(32'h0000_0000, 32'h0000_0000, 32'd0);
      send_record_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
      send_byte(8'h00);
      send_record_header(32'h0102_0304, MICROS_PER_SEC, 32'd2);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_record_header(32'h8000_0001, MICROS_PER_SEC - 32'd1, 32'd0);
      send_record_header($urandom, $urandom, 32'd3);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h01);

      random_start = bytes_sent;
      // long receiver hold-off while the sender offers bytes at full rate
      hold_req <= hold_req + 1;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
        set_traffic(bytes_sent - random_start);
        roll = $urandom_range(99);
        if (roll < 10) len = 0;
        else if (roll < 80) len = $urandom_range(12, 1);
        else if (roll < 95) len = $urandom_range(40, 13);
        else len = $urandom_range(100, 41);
        usecs = ($urandom_range(1) == 0) ? 32'($urandom_range(MICROS_PER_SEC - 1))
                                         : $urandom;
        send_record_header($urandom, usecs, len);
        send_payload(len);
      end

      // truncated file: the last record claims far more bytes than arrive
      send_record_header($urandom, $urandom, 32'hFFFF_FFFF);
      send_payload(30);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d bytes of a %s capture file (%s magic).", bytes_sent,
             file_big_endian ? "big-endian" : "little-endian",
             bad_run ? "invalid" : "valid");
    $display("Checked %0d record headers, %0d payload bytes, %0d bad-magic reports.",
             headers_seen, payload_seen, bad_magic_seen);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out waiting for the deframer.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/cfrd_pkg.sv
hw/rtl/cfrd_byte_if.sv
hw/rtl/cfrd_result_if.sv
hw/rtl/cfrd_parser.sv
hw/rtl/capture_file_record_deframer_top.sv
dv/capture_record_checker.sv
dv/tb_top.sv
